@@ hw/rtl/fjsd_pkg.sv @@
// ----------------------------------------------------------------------------
// fjsd_pkg
// Shared types and constants of the job slice dispatcher.
// ----------------------------------------------------------------------------
package fjsd_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int MAX_WORKERS_DEF = 64;
  localparam int JOB_IDS_DEF     = 256;

  localparam int NUMEL_W = 32;
  localparam int JID_W   = 8;
  localparam int WID_W   = 6;
  localparam int CFG_W   = 7;
  localparam int ST_W    = 3;
  localparam int FL_W    = 5;

  typedef enum logic [1:0] {
    CMD_ENQ  = 2'd0,
    CMD_REQ  = 2'd1,
    CMD_DONE = 2'd2,
    CMD_STOP = 2'd3
  } cmd_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK      = 3'd0,
    ST_STOPPED = 3'd1,
    ST_EMPTY   = 3'd2,
    ST_FULL    = 3'd3,
    ST_UNKNOWN = 3'd4,
    ST_BADWKR  = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_DIV,
    S_MUL,
    S_DONE_RD,
    S_CLEAR,
    S_OUT
  } state_t;

  typedef struct packed {
    logic                start;
    logic [NUMEL_W-1:0]  dividend;
    logic [CFG_W-1:0]    divisor;
  } div_req_t;

  typedef struct packed {
    logic                busy;
    logic                done;
    logic [NUMEL_W-1:0]  quot;
    logic [CFG_W-1:0]    rem;
  } div_rsp_t;

endpackage

@@ hw/rtl/fjsd_div.sv @@
// ----------------------------------------------------------------------------
// fjsd_div
// Radix-2 restoring divider, 32-bit dividend by 7-bit divisor, one bit per cycle.
// ----------------------------------------------------------------------------
module fjsd_div
  import fjsd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [NUMEL_W-1:0] q_r, q_nxt;
  logic [CFG_W:0]     rem_r, rem_nxt;
  logic [CFG_W-1:0]   d_r, d_nxt;
  logic [5:0]         cnt_r, cnt_nxt;
  logic               busy_r, busy_nxt, done_r, done_nxt;
  logic [CFG_W:0]     sh;

  always_comb begin
    q_nxt = q_r; rem_nxt = rem_r; d_nxt = d_r; cnt_nxt = cnt_r;
    busy_nxt = busy_r; done_nxt = 1'b0;
    sh = '0;
    if (req.start) begin
      q_nxt = req.dividend; rem_nxt = '0; d_nxt = req.divisor;
      cnt_nxt = 6'd32; busy_nxt = 1'b1;
    end else if (busy_r) begin
      sh = {rem_r[CFG_W-1:0], q_r[NUMEL_W-1]};
      if (sh >= {1'b0, d_r}) begin
        rem_nxt = sh - {1'b0, d_r};
        q_nxt   = {q_r[NUMEL_W-2:0], 1'b1};
      end else begin
        rem_nxt = sh;
        q_nxt   = {q_r[NUMEL_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt; rem_r <= rem_nxt; d_r <= d_nxt;
    if (!rst_n) begin
      cnt_r <= '0; busy_r <= 1'b0; done_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt; busy_r <= busy_nxt; done_r <= done_nxt;
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quot = q_r;
  assign rsp.rem  = rem_r[CFG_W-1:0];

endmodule

@@ hw/rtl/fifo_job_slice_dispatcher.sv @@
// ----------------------------------------------------------------------------
// fifo_job_slice_dispatcher
// Job FIFO with per-worker slice split and completion tracking.
// ----------------------------------------------------------------------------
//  channel | ports                      | handshake
//  in      | in_command .. in_worker_id | in_valid / in_stall
//  out     | out_status .. out_flushed  | out_valid / out_stall
//  cfg     | cfg_data (num_workers)     | cfg_valid / cfg_ready
//
// An enqueue goes through S_READ to S_OUT, a completion through S_READ, S_DONE_RD
// and S_OUT, a slice request through S_READ, S_DIV (the 32-step divider), S_MUL
// and S_OUT. One transaction in flight at a time. After reset and after a stop
// the completion table is swept, one entry per cycle; no input is taken meanwhile.
// A stalled result holds the block until it is taken.
module fifo_job_slice_dispatcher
  import fjsd_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int MAX_WORKERS = MAX_WORKERS_DEF,
  parameter int JOB_IDS     = JOB_IDS_DEF
)(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_command,
  input  logic [JID_W-1:0]   in_job_id,
  input  logic [NUMEL_W-1:0] in_job_numel,
  input  logic [WID_W-1:0]   in_worker_id,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [ST_W-1:0]    out_status,
  output logic [JID_W-1:0]   out_slice_job_id,
  output logic [NUMEL_W-1:0] out_slice_numel,
  output logic [NUMEL_W-1:0] out_slice_offset,
  output logic               out_last_slice,
  output logic               out_job_finished,
  output logic [FL_W-1:0]    out_flushed_jobs,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CFG_W-1:0]   cfg_data
);

  localparam int QA = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QC = $clog2(QUEUE_DEPTH + 1);
  localparam int JA = $clog2(JOB_IDS);
  localparam int DC = 8;
  localparam int PW = WID_W + NUMEL_W;

  // queue memories
  logic [JID_W-1:0]   qid_mem [QUEUE_DEPTH];
  logic [NUMEL_W-1:0] qsz_mem [QUEUE_DEPTH];
  logic [JID_W-1:0]   qid_rd_r;
  logic [NUMEL_W-1:0] qsz_rd_r;
  // completion table memory: {valid, count}
  logic [DC:0]        dt_mem [JOB_IDS];
  logic [DC:0]        dt_rd_r;
  logic               dt_we;
  logic [JA-1:0]      dt_wa, dt_ra;
  logic [DC:0]        dt_wd;
  logic               q_we;

  state_t state_r, state_nxt;
  logic [QA-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [QC-1:0] cnt_r, cnt_nxt;
  logic [CFG_W-1:0] left_r, left_nxt, nw_r;
  logic stop_r, stop_nxt;
  logic [JA:0] clr_r, clr_nxt;
  logic [1:0] cmd_r;
  logic [JID_W-1:0] jid_r;
  logic [NUMEL_W-1:0] numel_r;
  logic [WID_W-1:0] wid_r;
  logic [ST_W-1:0] o_st_r, o_st_nxt;
  logic [JID_W-1:0] o_id_r, o_id_nxt;
  logic [NUMEL_W-1:0] o_num_r, o_num_nxt, o_off_r, o_off_nxt;
  logic o_last_r, o_last_nxt, o_fin_r, o_fin_nxt;
  logic [FL_W-1:0] o_fl_r, o_fl_nxt;
  logic [CFG_W-1:0] w_eff;
  logic wid_ok, jid_ok;
  logic [PW-1:0] prod;
  logic [NUMEL_W-1:0] snum;
  logic [DC:0] dcnt;
  div_req_t dreq;
  div_rsp_t drsp;

  function automatic logic [QA-1:0] nextp(input logic [QA-1:0] p);
    return ({1'b0, p} + 1'b1 >= (QA+1)'(QUEUE_DEPTH)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    w_eff = nw_r;
    if (nw_r == '0) w_eff = 7'd1;
    if ({1'b0, nw_r} > 8'(MAX_WORKERS)) w_eff = CFG_W'(MAX_WORKERS);
  end

  assign wid_ok = {1'b0, wid_r} < w_eff;
  assign jid_ok = 32'(jid_r) < 32'(JOB_IDS);
  assign cfg_ready = (state_r == S_IDLE);
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);

  fjsd_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  assign snum = drsp.quot + ((WID_W+1)'(wid_r) < drsp.rem ? 32'd1 : 32'd0);
  assign prod = PW'(wid_r) * PW'(snum);
  assign dcnt = dt_rd_r + 1'b1;

  always_comb begin
    state_nxt = state_r; head_nxt = head_r; tail_nxt = tail_r; cnt_nxt = cnt_r;
    left_nxt = left_r; stop_nxt = stop_r; clr_nxt = clr_r;
    o_st_nxt = o_st_r; o_id_nxt = o_id_r; o_num_nxt = o_num_r; o_off_nxt = o_off_r;
    o_last_nxt = o_last_r; o_fin_nxt = o_fin_r; o_fl_nxt = o_fl_r;
    dreq = '0; dreq.dividend = qsz_rd_r; dreq.divisor = w_eff;
    dt_we = 1'b0; dt_wa = jid_r[JA-1:0]; dt_wd = '0; dt_ra = jid_r[JA-1:0];
    q_we = 1'b0;
    unique case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_READ;
      S_READ: begin
        o_st_nxt = ST_OK; o_id_nxt = '0; o_num_nxt = '0; o_off_nxt = '0;
        o_last_nxt = 1'b0; o_fin_nxt = 1'b0; o_fl_nxt = '0;
        state_nxt = S_OUT;
        if (cmd_r == CMD_STOP) begin
          if (!stop_r) begin
            o_fl_nxt = FL_W'(cnt_r);
            head_nxt = '0; tail_nxt = '0; cnt_nxt = '0; left_nxt = '0;
            stop_nxt = 1'b1; clr_nxt = '0; state_nxt = S_CLEAR;
          end
        end else if (stop_r) begin
          o_st_nxt = ST_STOPPED;
        end else if (cmd_r == CMD_ENQ) begin
          if (!jid_ok) o_st_nxt = ST_UNKNOWN;
          else if (cnt_r >= QC'(QUEUE_DEPTH)) o_st_nxt = ST_FULL;
          else begin
            q_we = 1'b1; tail_nxt = nextp(tail_r); cnt_nxt = cnt_r + 1'b1;
            dt_we = 1'b1; dt_wd = {1'b1, {DC{1'b0}}};
          end
        end else if (cmd_r == CMD_REQ) begin
          if (!wid_ok) o_st_nxt = ST_BADWKR;
          else if (cnt_r == '0) o_st_nxt = ST_EMPTY;
          else begin
            dreq.start = 1'b1; state_nxt = S_DIV;
          end
        end else begin
          if (!wid_ok) o_st_nxt = ST_BADWKR;
          else if (!jid_ok) o_st_nxt = ST_UNKNOWN;
          else state_nxt = S_DONE_RD;
        end
      end
      S_DIV: if (drsp.done) state_nxt = S_MUL;
      S_MUL: begin
        o_id_nxt = qid_rd_r; o_num_nxt = snum;
        o_off_nxt = prod[NUMEL_W-1:0] +
          (((WID_W+1)'(wid_r) < drsp.rem) ? 32'd0 : 32'(drsp.rem));
        if (left_r == '0 ? (w_eff == 7'd1) : (left_r == 7'd1)) begin
          left_nxt = '0; head_nxt = nextp(head_r); cnt_nxt = cnt_r - 1'b1;
          o_last_nxt = 1'b1;
        end else begin
          left_nxt = (left_r == '0 ? w_eff : left_r) - 1'b1;
        end
        state_nxt = S_OUT;
      end
      S_DONE_RD: begin
        if (!dt_rd_r[DC]) o_st_nxt = ST_UNKNOWN;
        else begin
          dt_we = 1'b1;
          if ({1'b0, dcnt[DC-1:0]} >= (DC+1)'(w_eff)) begin
            o_fin_nxt = 1'b1; dt_wd = '0;
          end else dt_wd = {1'b1, dcnt[DC-1:0]};
        end
        state_nxt = S_OUT;
      end
      S_CLEAR: begin
        dt_we = 1'b1; dt_wa = clr_r[JA-1:0]; dt_wd = '0;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == (JA+1)'(JOB_IDS - 1)) state_nxt = stop_r ? S_OUT : S_IDLE;
      end
      S_OUT: if (!out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_we) begin
      qid_mem[tail_r] <= jid_r;
      qsz_mem[tail_r] <= numel_r;
    end
    qid_rd_r <= qid_mem[head_r];
    qsz_rd_r <= qsz_mem[head_r];
  end

  always_ff @(posedge clk) begin
    if (dt_we) dt_mem[dt_wa] <= dt_wd;
    dt_rd_r <= dt_mem[dt_ra];
  end

  always_ff @(posedge clk) begin
    o_st_r <= o_st_nxt; o_id_r <= o_id_nxt; o_num_r <= o_num_nxt; o_off_r <= o_off_nxt;
    o_last_r <= o_last_nxt; o_fin_r <= o_fin_nxt; o_fl_r <= o_fl_nxt;
    if (state_r == S_IDLE && in_valid) begin
      cmd_r <= in_command; jid_r <= in_job_id;
      numel_r <= in_job_numel; wid_r <= in_worker_id;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR; head_r <= '0; tail_r <= '0; cnt_r <= '0; left_r <= '0;
      stop_r <= 1'b0; clr_r <= '0; nw_r <= 7'd1;
    end else begin
      state_r <= state_nxt; head_r <= head_nxt; tail_r <= tail_nxt; cnt_r <= cnt_nxt;
      left_r <= left_nxt; stop_r <= stop_nxt; clr_r <= clr_nxt;
      if (cfg_valid && cfg_ready) nw_r <= cfg_data;
    end
  end

  assign out_status       = o_st_r;
  assign out_slice_job_id = o_id_r;
  assign out_slice_numel  = o_num_r;
  assign out_slice_offset = o_off_r;
  assign out_last_slice   = o_last_r;
  assign out_job_finished = o_fin_r;
  assign out_flushed_jobs = o_fl_r;

endmodule

@@ hw/rtl/fjsd_checker.sv @@
// ----------------------------------------------------------------------------
// fjsd_checker
// Port-level checks of the job slice dispatcher.
// ----------------------------------------------------------------------------
module fjsd_checker
  import fjsd_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input logic [ST_W-1:0]  out_status,
  input logic [NUMEL_W-1:0] out_slice_numel,
  input logic             out_last_slice,
  input logic             out_job_finished,
  input logic [FL_W-1:0]  out_flushed_jobs
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status))
    else $error("result changed while stalled");

  a_one: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> !out_valid)
    else $error("result without work");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> !out_last_slice && !out_job_finished &&
      out_slice_numel == '0)
    else $error("failed transaction carries data");

  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_last_slice && out_job_finished) &&
      !(out_last_slice && out_flushed_jobs != '0))
    else $error("mixed result kinds");

endmodule

bind fifo_job_slice_dispatcher fjsd_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
  .out_slice_numel(out_slice_numel), .out_last_slice(out_last_slice),
  .out_job_finished(out_job_finished), .out_flushed_jobs(out_flushed_jobs)
);
